// ----- hw/rtl/lrr_pkg.sv -----
package lrr_pkg;

	// default sizes of the slot table and the draw
	localparam int SLOTS_DEF       = 16;
	localparam int TICKET_BITS_DEF = 8;
	localparam int RANDOM_BITS_DEF = 16;

	// request codes
	localparam logic [1:0] REQ_ADD   = 2'd0;
	localparam logic [1:0] REQ_SET   = 2'd1;
	localparam logic [1:0] REQ_SCHED = 2'd2;

	// scheduling modes
	localparam logic MODE_RR      = 1'b0;
	localparam logic MODE_LOTTERY = 1'b1;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_NOSLOT = 2'd2,
		ST_NONE   = 2'd3
	} status_t;

endpackage

// ----- hw/rtl/lottery_round_robin_scheduler.sv -----
// Slot scheduler with round-robin and ticket-lottery modes.
// Request channel: req_type, slot_index, ticket_count and random_fraction are
// taken at a rising edge where start is high and busy is low. Add, set, unused
// codes and round-robin schedules finish at that edge; their result appears in
// the next cycle and a new request may be taken in that same cycle.
// Lottery schedules on a non-empty table walk the ticket memory twice, one
// entry per cycle through its single read port: a sum over the entries, a
// multiply, then a search that stops at the winner; busy stays high meanwhile.
// On an empty table they finish like round robin; a zero sum skips the search.
// Result channel: done is high for exactly one cycle while grant_slot,
// grant_valid and status hold the result; the receiver cannot stall it.
// Configuration: cfg_we writes cfg_wdata into the mode register (0 round
// robin, 1 lottery); write it only while the block is idle.
// Reset: the table is empty, the round-robin pointer is at slot 0 and the
// mode is lottery. Ticket memory contents are not cleared; only written
// entries are ever read.
module lottery_round_robin_scheduler #(
	parameter int SLOTS       = lrr_pkg::SLOTS_DEF,
	parameter int TICKET_BITS = lrr_pkg::TICKET_BITS_DEF,
	parameter int RANDOM_BITS = lrr_pkg::RANDOM_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic                        cfg_wdata,
	input  logic                        start,
	output logic                        busy,
	input  logic [1:0]                  req_type,
	input  logic [$clog2(SLOTS)-1:0]    slot_index,
	input  logic [TICKET_BITS-1:0]      ticket_count,
	input  logic [RANDOM_BITS-1:0]      random_fraction,
	output logic                        done,
	output logic [$clog2(SLOTS)-1:0]    grant_slot,
	output logic                        grant_valid,
	output lrr_pkg::status_t            status
);

	import lrr_pkg::*;

	localparam int IDX_W = $clog2(SLOTS);

	logic                   mode_q;
	logic                   mem_we;
	logic [IDX_W-1:0]       mem_waddr;
	logic [TICKET_BITS-1:0] mem_wdata;
	logic                   mem_re;
	logic [IDX_W-1:0]       mem_raddr;
	logic [TICKET_BITS-1:0] mem_rdata;

	// mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_LOTTERY;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
		end
	end

	// request sequencer
	lrr_seq #(
		.SLOTS       (SLOTS),
		.TICKET_BITS (TICKET_BITS),
		.RANDOM_BITS (RANDOM_BITS),
		.IDX_W       (IDX_W)
	) u_seq (
		.clk             (clk),
		.arst_n          (arst_n),
		.mode            (mode_q),
		.start           (start),
		.busy            (busy),
		.req_type        (req_type),
		.slot_index      (slot_index),
		.ticket_count    (ticket_count),
		.random_fraction (random_fraction),
		.done            (done),
		.grant_slot      (grant_slot),
		.grant_valid     (grant_valid),
		.status          (status),
		.mem_we          (mem_we),
		.mem_waddr       (mem_waddr),
		.mem_wdata       (mem_wdata),
		.mem_re          (mem_re),
		.mem_raddr       (mem_raddr),
		.mem_rdata       (mem_rdata)
	);

	// ticket table
	lrr_ticket_mem #(
		.DEPTH (SLOTS),
		.WIDTH (TICKET_BITS),
		.AW    (IDX_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule

// ----- hw/rtl/lrr_ticket_mem.sv -----
module lrr_ticket_mem #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 8,
	parameter int AW    = 4
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- hw/rtl/lrr_seq.sv -----
module lrr_seq #(
	parameter int SLOTS       = 16,
	parameter int TICKET_BITS = 8,
	parameter int RANDOM_BITS = 16,
	parameter int IDX_W       = 4
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   mode,
	input  logic                   start,
	output logic                   busy,
	input  logic [1:0]             req_type,
	input  logic [IDX_W-1:0]       slot_index,
	input  logic [TICKET_BITS-1:0] ticket_count,
	input  logic [RANDOM_BITS-1:0] random_fraction,
	output logic                   done,
	output logic [IDX_W-1:0]       grant_slot,
	output logic                   grant_valid,
	output lrr_pkg::status_t       status,
	// ticket memory port
	output logic                   mem_we,
	output logic [IDX_W-1:0]       mem_waddr,
	output logic [TICKET_BITS-1:0] mem_wdata,
	output logic                   mem_re,
	output logic [IDX_W-1:0]       mem_raddr,
	input  logic [TICKET_BITS-1:0] mem_rdata
);

	import lrr_pkg::*;

	localparam int CNT_W  = $clog2(SLOTS + 1);
	localparam int SUM_W  = TICKET_BITS + IDX_W;
	localparam int PROD_W = SUM_W + RANDOM_BITS;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_SUM  = 4'b0010,
		S_MUL  = 4'b0100,
		S_PICK = 4'b1000
	} state_t;

	state_t                 state_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [IDX_W-1:0]       rr_q;
	logic [IDX_W-1:0]       pos_q;
	logic [SUM_W-1:0]       total_q;
	logic [SUM_W-1:0]       run_q;
	logic [SUM_W-1:0]       winner_q;
	logic [RANDOM_BITS-1:0] frac_q;
	logic                   done_q;
	logic [IDX_W-1:0]       grant_slot_q;
	logic                   grant_valid_q;
	status_t                status_q;

	logic                   accept;
	logic                   full;
	logic                   slot_ok;
	logic                   empty;
	logic                   lot_start;
	logic                   last;
	logic [IDX_W-1:0]       rr_grant;
	logic [IDX_W-1:0]       rr_next;
	logic [SUM_W-1:0]       total_next;
	logic [SUM_W-1:0]       run_next;
	logic                   hit;
	logic [PROD_W-1:0]      product;

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);

	// request checks against the table fill
	assign full      = (cnt_q == CNT_W'(SLOTS));
	assign slot_ok   = (CNT_W'(slot_index) < cnt_q);
	assign empty     = (cnt_q == '0);
	assign lot_start = accept && (req_type == REQ_SCHED) && !empty && (mode == MODE_LOTTERY);
	assign last      = (CNT_W'(pos_q) == (cnt_q - CNT_W'(1)));

	// round-robin pick and advance
	assign rr_grant = (CNT_W'(rr_q) < cnt_q) ? rr_q : '0;
	assign rr_next  = (rr_grant == IDX_W'(SLOTS - 1)) ? '0 : rr_grant + IDX_W'(1);

	// running sums over the entry read back this cycle
	assign total_next = total_q + SUM_W'(mem_rdata);
	assign run_next   = run_q + SUM_W'(mem_rdata);
	assign hit        = (run_next > winner_q);

	// winning number: total scaled by the random fraction
	assign product = PROD_W'(total_q) * PROD_W'(frac_q);

	// memory writes on add and set, reads during the two walks
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cnt_q[IDX_W-1:0];
		mem_wdata = TICKET_BITS'(1);
		mem_re    = 1'b0;
		mem_raddr = pos_q + IDX_W'(1);
		if (accept && (req_type == REQ_ADD) && !full) begin
			mem_we = 1'b1;
		end
		if (accept && (req_type == REQ_SET) && slot_ok) begin
			mem_we    = 1'b1;
			mem_waddr = slot_index;
			mem_wdata = ticket_count;
		end
		case (state_q)
			S_IDLE: begin
				if (lot_start) begin
					mem_re    = 1'b1;
					mem_raddr = '0;
				end
			end
			S_SUM: begin
				mem_re = !last;
			end
			S_MUL: begin
				mem_re    = (total_q != '0);
				mem_raddr = '0;
			end
			S_PICK: begin
				mem_re = !hit && !last;
			end
			default: begin
				mem_re = 1'b0;
			end
		endcase
	end

	// sequencer and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			cnt_q         <= '0;
			rr_q          <= '0;
			pos_q         <= '0;
			total_q       <= '0;
			run_q         <= '0;
			winner_q      <= '0;
			frac_q        <= '0;
			done_q        <= 1'b0;
			grant_slot_q  <= '0;
			grant_valid_q <= 1'b0;
			status_q      <= ST_OK;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						grant_slot_q  <= '0;
						grant_valid_q <= 1'b0;
						status_q      <= ST_OK;
						done_q        <= 1'b1;
						case (req_type)
							REQ_ADD: begin
								if (full) begin
									status_q <= ST_FULL;
								end else begin
									grant_slot_q  <= cnt_q[IDX_W-1:0];
									grant_valid_q <= 1'b1;
									cnt_q         <= cnt_q + CNT_W'(1);
								end
							end
							REQ_SET: begin
								if (!slot_ok) begin
									status_q <= ST_NOSLOT;
								end
							end
							REQ_SCHED: begin
								if (empty) begin
									status_q <= ST_NONE;
								end else if (mode == MODE_RR) begin
									grant_slot_q  <= rr_grant;
									grant_valid_q <= 1'b1;
									rr_q          <= rr_next;
								end else begin
									done_q  <= 1'b0;
									frac_q  <= random_fraction;
									pos_q   <= '0;
									total_q <= '0;
									state_q <= S_SUM;
								end
							end
							default: begin
								status_q <= ST_OK;
							end
						endcase
					end
				end
				S_SUM: begin
					total_q <= total_next;
					if (last) begin
						state_q <= S_MUL;
					end else begin
						pos_q <= pos_q + IDX_W'(1);
					end
				end
				S_MUL: begin
					if (total_q == '0) begin
						status_q <= ST_NONE;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						winner_q <= product[PROD_W-1:RANDOM_BITS];
						pos_q    <= '0;
						run_q    <= '0;
						state_q  <= S_PICK;
					end
				end
				S_PICK: begin
					run_q <= run_next;
					if (hit || last) begin
						grant_slot_q  <= pos_q;
						grant_valid_q <= 1'b1;
						status_q      <= ST_OK;
						done_q        <= 1'b1;
						state_q       <= S_IDLE;
					end else begin
						pos_q <= pos_q + IDX_W'(1);
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done        = done_q;
	assign grant_slot  = grant_slot_q;
	assign grant_valid = grant_valid_q;
	assign status      = status_q;

endmodule

// ----- verif/lottery_round_robin_scheduler_tb.sv -----
`timescale 1ns / 100ps

module lottery_round_robin_scheduler_tb;
	import lrr_pkg::*;

	// request code that the block answers with no grant and no effect
	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam int N_SEGMENTS = 6;
	localparam int SEGMENT_ITEMS = 290;
	// lottery walk of a full table plus a margin
	localparam int SETTLE_CYCLES = 40;
	localparam int DRAIN_LIMIT = 5000;

	typedef struct {
		logic [3:0] slot;
		logic       valid;
		status_t    status;
	} grant_t;

	// predicts every grant from the accepted requests and checks the outputs
	class sched_scoreboard;
		logic [TICKET_BITS_DEF-1:0] tickets [SLOTS_DEF];
		int unsigned n_entries;
		logic [3:0]  rr_next;
		logic        mode;
		grant_t      pending_grants [$];
		int unsigned n_errors;
		int unsigned n_requests, n_rr_grants, n_lottery_grants;
		int unsigned n_full, n_noslot, n_none;

		function new();
			foreach (tickets[i])
				tickets[i] = '0;
			n_entries = 0;
			rr_next = '0;
			mode = MODE_LOTTERY;
			n_errors = 0;
			n_requests = 0;
			n_rr_grants = 0;
			n_lottery_grants = 0;
			n_full = 0;
			n_noslot = 0;
			n_none = 0;
		endfunction

		function void set_mode(logic m);
			mode = m;
		endfunction

		// work out the grant for one accepted request and queue it
		function void note_request(logic [1:0] req, logic [3:0] slot,
				logic [7:0] tix, logic [15:0] frac);
			grant_t g;
			longint unsigned total, run, winner;
			int i;
			g.slot = '0;
			g.valid = 1'b0;
			g.status = ST_OK;
			n_requests++;
			case (req)
				REQ_ADD: begin
					if (n_entries >= SLOTS_DEF) begin
						g.status = ST_FULL;
					end else begin
						tickets[n_entries] = 1;
						g.slot = n_entries[3:0];
						g.valid = 1'b1;
						n_entries++;
					end
				end
				REQ_SET: begin
					if (slot >= n_entries)
						g.status = ST_NOSLOT;
					else
						tickets[slot] = tix;
				end
				REQ_SCHED: begin
					if (n_entries == 0) begin
						g.status = ST_NONE;
					end else if (mode == MODE_RR) begin
						g.slot = (rr_next < n_entries) ? rr_next : 4'd0;
						g.valid = 1'b1;
						// four bits wrap to slot 0 past the last slot
						rr_next = g.slot + 4'd1;
						n_rr_grants++;
					end else begin
						total = 0;
						for (i = 0; i < n_entries; i++)
							total += tickets[i];
						if (total == 0) begin
							g.status = ST_NONE;
						end else begin
							winner = (total * frac) >> RANDOM_BITS_DEF;
							run = 0;
							for (i = 0; i < n_entries; i++) begin
								run += tickets[i];
								if (run > winner) begin
									g.slot = i[3:0];
									g.valid = 1'b1;
									break;
								end
							end
							n_lottery_grants++;
						end
					end
				end
				default: ;
			endcase
			if (g.status == ST_FULL)
				n_full++;
			if (g.status == ST_NOSLOT)
				n_noslot++;
			if (g.status == ST_NONE)
				n_none++;
			pending_grants.push_back(g);
		endfunction

		// compare one result with the oldest prediction
		function void check_grant(logic [3:0] slot, logic valid, status_t st);
			grant_t want;
			if (pending_grants.size() == 0) begin
				$error("result with no request outstanding: slot %0d valid %0b status %0d",
					slot, valid, st);
				n_errors++;
				return;
			end
			want = pending_grants.pop_front();
			if (slot !== want.slot) begin
				$error("grant_slot: expected %0d, actual %0d", want.slot, slot);
				n_errors++;
			end
			if (valid !== want.valid) begin
				$error("grant_valid: expected %0b, actual %0b", want.valid, valid);
				n_errors++;
			end
			if (st !== want.status) begin
				$error("status: expected %0d, actual %0d", want.status, st);
				n_errors++;
			end
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic       cfg_wdata = 1'b0;
	logic       start = 1'b0;
	logic       busy;
	logic [1:0] req_type = '0;
	logic [3:0] slot_index = '0;
	logic [7:0] ticket_count = '0;
	logic [15:0] random_fraction = '0;
	logic       done;
	logic [3:0] grant_slot;
	logic       grant_valid;
	status_t    status;

	sched_scoreboard sb;
	int idle_pct;

	lottery_round_robin_scheduler uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.start          (start),
		.busy           (busy),
		.req_type       (req_type),
		.slot_index     (slot_index),
		.ticket_count   (ticket_count),
		.random_fraction(random_fraction),
		.done           (done),
		.grant_slot     (grant_slot),
		.grant_valid    (grant_valid),
		.status         (status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// results are only valid for the one cycle that done marks
	always @(posedge clk) begin
		if (done === 1'b1)
			sb.check_grant(grant_slot, grant_valid, status);
	end

	// hold start low with junk on the fields while a random draw stays under idle_pct
	task automatic sender_gap();
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			req_type <= 2'($urandom);
			slot_index <= 4'($urandom);
			ticket_count <= 8'($urandom);
			random_fraction <= 16'($urandom);
			@(posedge clk);
		end
	endtask

	// present one request and wait until the block takes it
	task automatic send_request(logic [1:0] req, logic [3:0] slot, logic [7:0] tix,
			logic [15:0] frac);
		sender_gap();
		start <= 1'b1;
		req_type <= req;
		slot_index <= slot;
		ticket_count <= tix;
		random_fraction <= frac;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		sb.note_request(req, slot, tix, frac);
	endtask

	// wait for all outstanding results, then for the block to settle
	task automatic drain();
		int k;
		start <= 1'b0;
		for (k = 0; k < DRAIN_LIMIT && sb.pending_grants.size() != 0; k++)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_mode(logic m);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_mode(m);
	endtask

	// random request, weighted towards schedules and ticket changes
	task automatic send_random();
		logic [1:0]  req;
		logic [7:0]  tix;
		logic [15:0] frac;
		int r;
		r = $urandom_range(99);
		if (r < 18)
			req = REQ_ADD;
		else if (r < 50)
			req = REQ_SET;
		else if (r < 95)
			req = REQ_SCHED;
		else
			req = REQ_UNUSED;
		r = $urandom_range(9);
		if (r < 3)
			tix = 8'd0;
		else if (r == 3)
			tix = 8'hff;
		else if (r == 4)
			tix = 8'd1;
		else
			tix = 8'($urandom_range(255));
		r = $urandom_range(9);
		if (r == 0)
			frac = 16'h0000;
		else if (r == 1)
			frac = 16'hffff;
		else
			frac = 16'($urandom_range(65535));
		send_request(req, 4'($urandom_range(15)), tix, frac);
	endtask

	initial begin
		int seg_idle [N_SEGMENTS];
		logic seg_mode [N_SEGMENTS];
		int s;
		seg_idle = '{31, 31, 63, 63, 0, 0};
		seg_mode = '{MODE_RR, MODE_LOTTERY, MODE_LOTTERY, MODE_RR, MODE_RR, MODE_LOTTERY};
		sb = new();
		idle_pct = 31;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// lottery mode out of reset: empty table, unknown slots, zero tickets
		send_request(REQ_SCHED, 4'd0, 8'd0, 16'h0000);
		send_request(REQ_SET, 4'd0, 8'd5, 16'h0000);
		send_request(REQ_UNUSED, 4'hf, 8'hff, 16'hffff);
		send_request(REQ_ADD, 4'd0, 8'd0, 16'h0000);
		send_request(REQ_SET, 4'd0, 8'd0, 16'h0000);
		send_request(REQ_SCHED, 4'd0, 8'd0, 16'hffff);
		send_request(REQ_SET, 4'd0, 8'hff, 16'h0000);
		send_request(REQ_SCHED, 4'd0, 8'd0, 16'hffff);
		send_request(REQ_ADD, 4'd0, 8'd0, 16'h0000);
		send_request(REQ_SET, 4'd1, 8'hff, 16'h0000);
		send_request(REQ_SCHED, 4'd0, 8'd0, 16'h0000);
		send_request(REQ_SCHED, 4'd0, 8'd0, 16'hffff);
		send_request(REQ_SET, 4'hf, 8'hff, 16'h0000);
		send_request(REQ_SET, 4'd2, 8'd7, 16'h0000);

		// round robin, including the pointer sitting past the last entry
		write_mode(MODE_RR);
		repeat (3) send_request(REQ_SCHED, 4'd0, 8'd0, 16'h0000);
		send_request(REQ_ADD, 4'd0, 8'd0, 16'h0000);
		repeat (3) send_request(REQ_SCHED, 4'd0, 8'd0, 16'h0000);

		// random segments over both modes and all idling levels
		for (s = 0; s < N_SEGMENTS; s++) begin
			write_mode(seg_mode[s]);
			idle_pct = seg_idle[s];
			repeat (SEGMENT_ITEMS) send_random();
		end

		drain();
		if (sb.pending_grants.size() != 0) begin
			$error("%0d results never arrived", sb.pending_grants.size());
			sb.n_errors += sb.pending_grants.size();
		end
		$display("covered %0d requests: %0d round-robin and %0d lottery grants",
			sb.n_requests, sb.n_rr_grants, sb.n_lottery_grants);
		$display("refusals: %0d table full, %0d missing slot, %0d nothing to grant",
			sb.n_full, sb.n_noslot, sb.n_none);
		if (sb.n_errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// overall time limit
	initial begin
		#10_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
